>>> hw/rtl/lshm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lshm_pkg
// shared types and constants of the latency histogram monitor
// ----------------------------------------------------------------------------
package lshm_pkg;

   localparam int NUM_SOURCES = 4;
   localparam int NUM_BINS    = 7;
   localparam int SRC_W       = 2;
   localparam int BIN_W       = 3;

   localparam logic [31:0] SLOW_RESET   = 32'd10000;
   localparam logic [31:0] WINDOW_RESET = 32'd10000000;
   // ceil(2^38 / 1000), exact quotient by 1000 for any 32-bit value
   localparam logic [31:0] MS_RECIP     = 32'd274877907;

   localparam logic [0:0] CSR_SLOW   = 1'b0;
   localparam logic [0:0] CSR_WINDOW = 1'b1;

   typedef enum logic [3:0] {
      KIND_WINDOW_MS = 4'd0,
      KIND_CALLS     = 4'd1,
      KIND_ERRORS    = 4'd2,
      KIND_SLOW      = 4'd3,
      KIND_TOTAL     = 4'd4,
      KIND_AVG       = 4'd5,
      KIND_MAX       = 4'd6,
      KIND_BUSY      = 4'd7,
      KIND_PACKETS   = 4'd8,
      KIND_BIN0      = 4'd9,
      KIND_BIN6      = 4'd15
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCALE,
      ST_DIV_AVG,
      ST_DIV_BUSY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  source;
      logic [31:0] duration_us;
      logic        failed;
      logic [31:0] packet_count;
      logic [31:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  report_source;
      logic [3:0]  stat_kind;
      logic [63:0] stat_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_sts_type;

   function automatic logic [BIN_W-1:0] pick_bin(input logic [31:0] t);
      logic [BIN_W-1:0] b;
      if (t <= 32'd500) b = 3'd0;
      else if (t <= 32'd1000) b = 3'd1;
      else if (t <= 32'd2000) b = 3'd2;
      else if (t <= 32'd5000) b = 3'd3;
      else if (t <= 32'd10000) b = 3'd4;
      else if (t <= 32'd20000) b = 3'd5;
      else b = 3'd6;
      return b;
   endfunction

endpackage

>>> hw/rtl/lshm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lshm_divider
// shared restoring divider, 64 by 32 bits, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lshm_divider
   import lshm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

>>> hw/rtl/latency_stats_histogram_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_stats_histogram_monitor_core
// per-bank latency statistics with windowed 16-item reports
// ----------------------------------------------------------------------------
// an event without report passes through the update state, then the block is idle again
// a closing event adds a scaling step and two divisions (avg, busy)
// in the shared divider and 16 report transfers
// one event at a time; a new event is taken only back in idle
// synchronous reset clears all banks and restores the register defaults
// ----------------------------------------------------------------------------
module latency_stats_histogram_monitor_core
   import lshm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [31:0] slow_ff, window_ff;

   // bank statistics, cleared by reset
   logic [31:0] start_ff   [NUM_SOURCES];
   logic [31:0] calls_ff   [NUM_SOURCES];
   logic [31:0] errors_ff  [NUM_SOURCES];
   logic [31:0] slowc_ff   [NUM_SOURCES];
   logic [63:0] total_ff   [NUM_SOURCES];
   logic [31:0] max_ff     [NUM_SOURCES];
   logic [63:0] packets_ff [NUM_SOURCES];
   logic [31:0] bins_ff    [NUM_SOURCES][NUM_BINS];

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [31:0] win_ff;
   logic [31:0] ms_ff, avg_ff, busy_ff;
   logic [3:0]  kind_ff;
   logic [63:0] scaled_ff;

   // snapshot of the closing bank
   logic [31:0] s_calls_ff, s_errors_ff, s_slow_ff, s_max_ff;
   logic [63:0] s_total_ff, s_packets_ff;
   logic [31:0] s_bins_ff [NUM_BINS];

   div_cmd_type div_cmd;
   div_sts_type div_sts;
   logic        div_pending_ff;

   logic [SRC_W-1:0] src;
   logic [31:0] n_start, n_calls, n_errors, n_slow, n_max;
   logic [63:0] n_total, n_packets;
   logic [BIN_W-1:0] bin_sel;
   logic [31:0] n_win;
   logic        close;
   logic [63:0] ms_prod;

   assign src = req_ff.source;

   // window in ms by reciprocal multiplication, quotient sits from bit 38
   assign ms_prod = {32'd0, win_ff} * {32'd0, MS_RECIP};

   // updated bank values for the held event
   always_comb begin
      n_start   = (start_ff[src] == 32'd0) ? req_ff.now_us : start_ff[src];
      n_calls   = calls_ff[src] + 32'd1;
      n_errors  = errors_ff[src] + {31'd0, req_ff.failed};
      n_slow    = slowc_ff[src] + {31'd0, (req_ff.duration_us >= slow_ff)};
      n_total   = total_ff[src] + {32'd0, req_ff.duration_us};
      n_max     = (req_ff.duration_us > max_ff[src]) ? req_ff.duration_us : max_ff[src];
      n_packets = packets_ff[src] + {32'd0, req_ff.packet_count};
      bin_sel   = pick_bin(req_ff.duration_us);
      n_win     = req_ff.now_us - n_start;
      close     = (n_win >= window_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_UPDATE;
         ST_UPDATE:   state_in = close ? ST_SCALE : ST_IDLE;
         ST_SCALE:    state_in = ST_DIV_AVG;
         ST_DIV_AVG:  if (div_sts.done) state_in = ST_DIV_BUSY;
         ST_DIV_BUSY: if (div_sts.done) state_in = ST_EMIT;
         ST_EMIT:     if (rsp_ready && kind_ff == KIND_BIN6) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // divider commands
   always_comb begin
      div_cmd = '0;
      case (state_ff)
         ST_DIV_AVG: begin
            div_cmd.start    = div_pending_ff;
            div_cmd.dividend = s_total_ff;
            div_cmd.divisor  = (s_calls_ff == 32'd0) ? 32'd1 : s_calls_ff;
         end
         ST_DIV_BUSY: begin
            // zero window is handled when the busy result is stored
            div_cmd.start    = div_pending_ff;
            div_cmd.dividend = scaled_ff;
            div_cmd.divisor  = (win_ff == 32'd0) ? 32'd1 : win_ff;
         end
         default: div_cmd = '0;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      rsp_data.report_source = src;
      rsp_data.stat_kind     = kind_ff;
      rsp_data.last          = (kind_ff == KIND_BIN6);
      case (kind_ff)
         KIND_WINDOW_MS: rsp_data.stat_value = {32'd0, ms_ff};
         KIND_CALLS:     rsp_data.stat_value = {32'd0, s_calls_ff};
         KIND_ERRORS:    rsp_data.stat_value = {32'd0, s_errors_ff};
         KIND_SLOW:      rsp_data.stat_value = {32'd0, s_slow_ff};
         KIND_TOTAL:     rsp_data.stat_value = s_total_ff;
         KIND_AVG:       rsp_data.stat_value = {32'd0, avg_ff};
         KIND_MAX:       rsp_data.stat_value = {32'd0, s_max_ff};
         KIND_BUSY:      rsp_data.stat_value = {32'd0, busy_ff};
         KIND_PACKETS:   rsp_data.stat_value = s_packets_ff;
         default:        rsp_data.stat_value =
                            {32'd0, s_bins_ff[BIN_W'(kind_ff - KIND_BIN0)]};
      endcase
   end

   lshm_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slow_ff        <= SLOW_RESET;
         window_ff      <= WINDOW_RESET;
         div_pending_ff <= 1'b0;
         kind_ff        <= KIND_WINDOW_MS;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            start_ff[i]   <= '0;
            calls_ff[i]   <= '0;
            errors_ff[i]  <= '0;
            slowc_ff[i]   <= '0;
            total_ff[i]   <= '0;
            max_ff[i]     <= '0;
            packets_ff[i] <= '0;
            for (int j = 0; j < NUM_BINS; j++) bins_ff[i][j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SLOW:   slow_ff   <= csr_wdata;
               CSR_WINDOW: window_ff <= csr_wdata;
               default:    ;
            endcase
         end
         if (req_valid && req_ready) req_ff <= req_data;
         if (div_cmd.start) div_pending_ff <= 1'b0;
         if (div_sts.done) div_pending_ff <= 1'b1;
         case (state_ff)
            ST_UPDATE: begin
               win_ff         <= n_win;
               div_pending_ff <= 1'b1;
               kind_ff        <= KIND_WINDOW_MS;
               s_calls_ff     <= n_calls;
               s_errors_ff    <= n_errors;
               s_slow_ff      <= n_slow;
               s_total_ff     <= n_total;
               s_max_ff       <= n_max;
               s_packets_ff   <= n_packets;
               for (int j = 0; j < NUM_BINS; j++)
                  s_bins_ff[j] <= bins_ff[src][j] + {31'd0, (bin_sel == BIN_W'(j))};
               if (close) begin
                  // clear the bank and restart the window now
                  start_ff[src]   <= req_ff.now_us;
                  calls_ff[src]   <= '0;
                  errors_ff[src]  <= '0;
                  slowc_ff[src]   <= '0;
                  total_ff[src]   <= '0;
                  max_ff[src]     <= '0;
                  packets_ff[src] <= '0;
                  for (int j = 0; j < NUM_BINS; j++) bins_ff[src][j] <= '0;
               end else begin
                  start_ff[src]   <= n_start;
                  calls_ff[src]   <= n_calls;
                  errors_ff[src]  <= n_errors;
                  slowc_ff[src]   <= n_slow;
                  total_ff[src]   <= n_total;
                  max_ff[src]     <= n_max;
                  packets_ff[src] <= n_packets;
                  bins_ff[src][bin_sel] <= bins_ff[src][bin_sel] + 32'd1;
               end
            end
            ST_SCALE: begin
               ms_ff     <= {6'd0, ms_prod[63:38]};
               // total times 10000 as a sum of shifts, wraps at 64 bits
               scaled_ff <= (s_total_ff << 13) + (s_total_ff << 10)
                            + (s_total_ff << 9) + (s_total_ff << 8)
                            + (s_total_ff << 4);
            end
            ST_DIV_AVG:  if (div_sts.done) avg_ff <= div_sts.quotient[31:0];
            ST_DIV_BUSY: if (div_sts.done)
               busy_ff <= (win_ff == 32'd0) ? 32'd0 : div_sts.quotient[31:0];
            ST_EMIT:     if (rsp_ready) kind_ff <= kind_ff + 4'd1;
            default:     ;
         endcase
      end
   end

   // a report transfer never happens while an event is being taken
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && req_ready))
      else $error("report and request overlap");
   // the final report item returns the block to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last) |=> req_ready)
      else $error("not idle after last report item");
   // divider finishes only inside a division phase
   assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DIV_AVG || state_ff == ST_DIV_BUSY))
      else $error("divider result outside division phase");

endmodule
